@@ src/ismu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ismu_pkg: shared types and constants of the Ising spin update unit
// Field widths, item kinds, queue entry and accept-level bundle.
// ----------------------------------------------------------------------------
package ismu_pkg;

   localparam int SIDE_DEFAULT = 8;

   localparam int COORD_W     = 3;   // row / col field width
   localparam int RND_W       = 16;  // random fraction, Q0.16
   localparam int LEVEL_W     = 17;  // accept level, Q0.16 plus "always" bit
   localparam int SUM_W       = 8;   // magnetization / energy width
   localparam int NUM_LEVELS  = 4;   // dE = 2, 4, 6, 8
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 2;   // power of two
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LEVEL_W-1:0] LEVEL_ALWAYS = LEVEL_W'(65536);

   typedef enum logic {
      KIND_LOAD   = 1'b0,
      KIND_UPDATE = 1'b1
   } kind_type;

   typedef logic [NUM_LEVELS-1:0][LEVEL_W-1:0] accept_levels_type;

   // one classified item waiting for the back end
   typedef struct packed {
      kind_type           kind;
      logic               in_site;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               spin_up;
      logic [RND_W-1:0]   rnd;
   } queue_entry_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

endpackage
`default_nettype wire

@@ src/ismu_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ismu_front: input side of the spin update unit
// Takes items while the queue has room and tags sites outside the lattice.
// ----------------------------------------------------------------------------
module ismu_front
   import ismu_pkg::*;
#(
   parameter int SIDE = SIDE_DEFAULT
) (
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_kind,
   input  wire logic [COORD_W-1:0]  req_row,
   input  wire logic [COORD_W-1:0]  req_col,
   input  wire logic                req_spin_up,
   input  wire logic [RND_W-1:0]    req_random_fraction,
   input  wire queue_status_type    q_status,
   output logic                     push,
   output queue_entry_type          push_entry
);

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      push_entry.kind    = kind_type'(req_kind);
      push_entry.in_site = (int'(req_row) < SIDE) && (int'(req_col) < SIDE);
      push_entry.row     = req_row;
      push_entry.col     = req_col;
      push_entry.spin_up = req_spin_up;
      push_entry.rnd     = req_random_fraction;
   end

endmodule
`default_nettype wire

@@ src/ismu_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ismu_queue: short FIFO between front and back end
// Register-based, push and pop in the same cycle allowed.
// ----------------------------------------------------------------------------
module ismu_queue
   import ismu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire queue_entry_type  push_entry,
   input  wire logic             pop,
   output queue_entry_type       head_entry,
   output queue_status_type      q_status
);

   queue_entry_type    entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign head_entry     = entries_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign q_status.count = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

@@ src/ismu_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ismu_back: lattice, Metropolis decision and running sums
// One item per cycle unless stalled: neighbour lookup, dE, accept, flip, sums.
// ----------------------------------------------------------------------------
module ismu_back
   import ismu_pkg::*;
#(
   parameter int SIDE = SIDE_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire queue_entry_type    head_entry,
   input  wire accept_levels_type  accept_levels,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_flipped,
   output logic signed [SUM_W-1:0] rsp_magnetization,
   output logic signed [SUM_W-1:0] rsp_energy
);

   localparam int IDX_W = $clog2(SIDE);
   localparam logic [SUM_W-1:0] MAG_RESET    = SUM_W'(SIDE * SIDE);
   localparam logic [SUM_W-1:0] ENERGY_RESET = SUM_W'(-2 * SIDE * (SIDE - 1));
   localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(SIDE - 1);

   logic [SIDE-1:0][SIDE-1:0] lattice_ff, lattice_in;
   logic [SUM_W-1:0]          magnet_ff, magnet_in;
   logic [SUM_W-1:0]          energy_ff, energy_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      flipped_ff, flipped_in;

   logic [IDX_W-1:0]          r;
   logic [IDX_W-1:0]          c;
   logic                      s;
   logic signed [3:0]         nb_sum;
   logic signed [4:0]         twice_sum;
   logic signed [4:0]         delta_e;
   logic [1:0]                lvl_sel;
   logic                      accept;
   logic                      flip;
   logic                      out_free;

   assign r = IDX_W'(head_entry.row);
   assign c = IDX_W'(head_entry.col);
   assign s = lattice_ff[r][c];

   // open boundaries: missing neighbours contribute nothing
   always_comb begin
      nb_sum = '0;
      if (r != '0) begin
         nb_sum = nb_sum + (lattice_ff[r - IDX_W'(1)][c] ? 4'sd1 : -4'sd1);
      end
      if (r < LAST_IDX) begin
         nb_sum = nb_sum + (lattice_ff[r + IDX_W'(1)][c] ? 4'sd1 : -4'sd1);
      end
      if (c != '0) begin
         nb_sum = nb_sum + (lattice_ff[r][c - IDX_W'(1)] ? 4'sd1 : -4'sd1);
      end
      if (c < LAST_IDX) begin
         nb_sum = nb_sum + (lattice_ff[r][c + IDX_W'(1)] ? 4'sd1 : -4'sd1);
      end
   end

   assign twice_sum = $signed({nb_sum, 1'b0});
   assign delta_e   = s ? twice_sum : -twice_sum;

   // positive dE is one of 2, 4, 6, 8 -> level 0..3
   assign lvl_sel = 2'(delta_e[3:1] - 3'd1);
   assign accept  = (delta_e <= 5'sd0) ||
                    (accept_levels[lvl_sel] > {1'b0, head_entry.rnd});

   always_comb begin
      if (!head_entry.in_site) begin
         flip = 1'b0;
      end else begin
         unique case (head_entry.kind)
            KIND_LOAD:   flip = (s != head_entry.spin_up);
            KIND_UPDATE: flip = accept;
            default:     flip = 1'b0;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = head_valid && out_free;

   always_comb begin
      lattice_in   = lattice_ff;
      magnet_in    = magnet_ff;
      energy_in    = energy_ff;
      flipped_in   = flipped_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = pop;
      end
      if (pop) begin
         flipped_in = flip;
         if (flip) begin
            lattice_in[r][c] = !s;
            magnet_in        = magnet_ff + (s ? SUM_W'(-2) : SUM_W'(2));
            energy_in        = energy_ff + SUM_W'(delta_e);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lattice_ff   <= '1;
         magnet_ff    <= MAG_RESET;
         energy_ff    <= ENERGY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         lattice_ff   <= lattice_in;
         magnet_ff    <= magnet_in;
         energy_ff    <= energy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flipped_ff <= flipped_in;
   end

   // sums only move on a pop, which needs the output slot free, so they
   // always describe the item on display
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_flipped       = flipped_ff;
   assign rsp_magnetization = $signed(magnet_ff);
   assign rsp_energy        = $signed(energy_ff);

endmodule
`default_nettype wire

@@ src/ising_metropolis_spin_update_unit.sv @@
`default_nettype none
// Path: an accepted item waits in the queue registers, then in the output slot.
// Throughput: one item per cycle unless rsp_stall holds the output slot; the
//   back end's read-modify-write of flop lattice and running sums sets that rate.
// Reset (synchronous): all spins +1, magnetization SIDE*SIDE, energy
//   -2*SIDE*(SIDE-1), accept levels 65536, queue and output slot empty.
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update_unit: Metropolis single-spin-flip Ising engine
// SIDE x SIDE lattice with open boundaries, J = 1, no field. Front end takes
// items into a two-entry queue; back end flips spins and keeps the sums.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update_unit
   import ismu_pkg::*;
#(
   parameter int SIDE = SIDE_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // configuration
   input  wire logic                csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [LEVEL_W-1:0]  csr_write_data,
   // request items
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_kind,
   input  wire logic [COORD_W-1:0]  req_row,
   input  wire logic [COORD_W-1:0]  req_col,
   input  wire logic                req_spin_up,
   input  wire logic [RND_W-1:0]    req_random_fraction,
   // result items
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_flipped,
   output logic signed [SUM_W-1:0]  rsp_magnetization,
   output logic signed [SUM_W-1:0]  rsp_energy
);

   localparam logic [SUM_W-1:0] MAG_RESET    = SUM_W'(SIDE * SIDE);
   localparam logic [SUM_W-1:0] ENERGY_RESET = SUM_W'(-2 * SIDE * (SIDE - 1));

   // accept levels for dE = 2, 4, 6, 8; the index covers exactly the four
   accept_levels_type accept_levels_ff, accept_levels_in;

   always_comb begin
      accept_levels_in = accept_levels_ff;
      if (csr_write_en) begin
         accept_levels_in[csr_index] = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accept_levels_ff <= {NUM_LEVELS{LEVEL_ALWAYS}};
      end else begin
         accept_levels_ff <= accept_levels_in;
      end
   end

   // front end -> queue -> back end
   logic             push;
   logic             pop;
   queue_entry_type  push_entry;
   queue_entry_type  head_entry;
   queue_status_type q_status;

   ismu_front #(
      .SIDE (SIDE)
   ) u_front (
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_row             (req_row),
      .req_col             (req_col),
      .req_spin_up         (req_spin_up),
      .req_random_fraction (req_random_fraction),
      .q_status            (q_status),
      .push                (push),
      .push_entry          (push_entry)
   );

   ismu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   // back end owns the lattice and the output slot
   ismu_back #(
      .SIDE (SIDE)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (!q_status.empty),
      .head_entry        (head_entry),
      .accept_levels     (accept_levels_ff),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_flipped       (rsp_flipped),
      .rsp_magnetization (rsp_magnetization),
      .rsp_energy        (rsp_energy)
   );

`ifndef NO_ASSERTIONS
   // every flip moves magnetization by 2, so its parity never changes
   a_mag_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_magnetization[0] == MAG_RESET[0]))
      else $error("magnetization parity broken");

   // dE is always even, so energy parity never changes
   a_energy_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_energy[0] == ENERGY_RESET[0]))
      else $error("energy parity broken");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("back end popped an empty queue");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue overfilled");
`endif

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Ising Metropolis spin update unit
// Drives load and update items at the 8x8 lattice under several sets of
// acceptance levels. A local model of the lattice, the running sums and the
// levels predicts results with no hand-written value; checked in order, field by field.
// ----------------------------------------------------------------------------
module tb
   import ismu_pkg::*;
();

   localparam int LATTICE_SIDE = SIDE_DEFAULT;
   localparam int RANDOM_ITEMS = 850;
   localparam int HOLD_CYCLES  = 60;   // long receiver hold-off, fills the block
   localparam int DRAIN_CYCLES = 8;    // extra edges at the end, after the drain

   // accept-level register map
   localparam logic [CSR_IDX_W-1:0] ACCEPT_DE2 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] ACCEPT_DE4 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] ACCEPT_DE6 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] ACCEPT_DE8 = 2'd3;

   typedef struct {
      kind_type           kind;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               spin_up;
      logic [RND_W-1:0]   rnd;
   } spin_item_type;

   typedef struct {
      logic               flipped;
      logic signed [SUM_W-1:0] magnetization;
      logic signed [SUM_W-1:0] energy;
   } spin_result_type;

   typedef enum { ROW_ITEM, ROW_LEVELS } row_op_type;

   // one line of the directed table: an item, or a full set of accept levels
   typedef struct {
      row_op_type        op;
      spin_item_type     item;
      bit                typed;    // want holds a hand-written result
      spin_result_type   want;
      accept_levels_type levels;
   } table_row_type;

   // DUT inputs, all known from time 0
   logic                 clock;
   logic                 reset          = 1'b1;
   logic                 csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = '0;
   logic [LEVEL_W-1:0]   csr_write_data = '0;
   logic                 req_valid      = 1'b0;
   logic                 req_kind       = 1'b0;
   logic [COORD_W-1:0]   req_row        = '0;
   logic [COORD_W-1:0]   req_col        = '0;
   logic                 req_spin_up    = 1'b0;
   logic [RND_W-1:0]     req_random_fraction = '0;
   logic                 rsp_stall      = 1'b0;

   // DUT outputs
   logic                    req_stall;
   logic                    rsp_valid;
   logic                    rsp_flipped;
   logic signed [SUM_W-1:0] rsp_magnetization;
   logic signed [SUM_W-1:0] rsp_energy;

   // lattice model: spin state, running sums, accept levels
   bit                      lattice_up [LATTICE_SIDE][LATTICE_SIDE];
   logic signed [SUM_W-1:0] magnet_sum;
   logic signed [SUM_W-1:0] energy_sum;
   accept_levels_type       level_cfg;

   spin_result_type expected_results [$];
   table_row_type   directed_rows [$];
   int              error_count  = 0;
   int              burst_left   = 0;
   bit              hold_results = 1'b0;   // main asks receiver for a long hold

   ising_metropolis_spin_update_unit #(.SIDE(LATTICE_SIDE)) DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_row             (req_row),
      .req_col             (req_col),
      .req_spin_up         (req_spin_up),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_flipped         (rsp_flipped),
      .rsp_magnetization   (rsp_magnetization),
      .rsp_energy          (rsp_energy)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop in case the handshake hangs
   initial begin
      #3_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // ------------------------------------------------------------------
   // Lattice model
   // ------------------------------------------------------------------
   function automatic void reset_lattice();
      foreach (lattice_up[r, c]) lattice_up[r][c] = 1'b1;
      magnet_sum = SUM_W'(LATTICE_SIDE * LATTICE_SIDE);
      energy_sum = SUM_W'(-2 * LATTICE_SIDE * (LATTICE_SIDE - 1));
      for (int i = 0; i < NUM_LEVELS; i++) level_cfg[i] = LEVEL_ALWAYS;
   endfunction

   function automatic int spin_of(int r, int c);
      return lattice_up[r][c] ? 1 : -1;
   endfunction

   // Apply one item to the model and return what the block must report.
   function automatic spin_result_type apply_item(spin_item_type it);
      spin_result_type res;
      int  r, c, s, nsum, delta;
      bit  take;
      r = it.row;
      c = it.col;
      s = spin_of(r, c);
      // open boundaries: edge and corner sites have fewer neighbours
      nsum = 0;
      if (r > 0)                nsum += spin_of(r - 1, c);
      if (r < LATTICE_SIDE - 1) nsum += spin_of(r + 1, c);
      if (c > 0)                nsum += spin_of(r, c - 1);
      if (c < LATTICE_SIDE - 1) nsum += spin_of(r, c + 1);
      delta = 2 * s * nsum;
      if (it.kind == KIND_LOAD)
         take = (lattice_up[r][c] != it.spin_up);
      else if (delta <= 0)
         take = 1'b1;
      else   // dE of 2/4/6/8 selects level 0..3; strict greater-than
         take = (level_cfg[delta / 2 - 1] > {1'b0, it.rnd});
      if (take) begin
         magnet_sum = magnet_sum - SUM_W'(2 * s);
         energy_sum = energy_sum + SUM_W'(delta);
         lattice_up[r][c] = !lattice_up[r][c];
      end
      res.flipped       = take;
      res.magnetization = magnet_sum;
      res.energy        = energy_sum;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Directed table construction
   // ------------------------------------------------------------------
   function automatic void add_item(kind_type k, int r, int c, bit up, int rnd);
      table_row_type row;
      row.op           = ROW_ITEM;
      row.item.kind    = k;
      row.item.row     = COORD_W'(r);
      row.item.col     = COORD_W'(c);
      row.item.spin_up = up;
      row.item.rnd     = RND_W'(rnd);
      row.typed        = 1'b0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked(kind_type k, int r, int c, bit up, int rnd,
                                       bit f, int m, int e);
      table_row_type row;
      add_item(k, r, c, up, rnd);
      row = directed_rows.pop_back();
      row.typed              = 1'b1;
      row.want.flipped       = f;
      row.want.magnetization = SUM_W'(m);
      row.want.energy        = SUM_W'(e);
      directed_rows.push_back(row);
   endfunction

   function automatic void add_levels(int d2, int d4, int d6, int d8);
      table_row_type row;
      row.op = ROW_LEVELS;
      row.levels[ACCEPT_DE2] = LEVEL_W'(d2);
      row.levels[ACCEPT_DE4] = LEVEL_W'(d4);
      row.levels[ACCEPT_DE6] = LEVEL_W'(d6);
      row.levels[ACCEPT_DE8] = LEVEL_W'(d8);
      directed_rows.push_back(row);
   endfunction

   // ------------------------------------------------------------------
   // Random content
   // ------------------------------------------------------------------
   function automatic accept_levels_type random_levels();
      accept_levels_type lv;
      for (int i = 0; i < NUM_LEVELS; i++)
         case ($urandom_range(0, 5))
            0:       lv[i] = '0;
            1:       lv[i] = LEVEL_ALWAYS;
            2:       lv[i] = LEVEL_W'(65535);
            default: lv[i] = LEVEL_W'($urandom_range(0, 65536));
         endcase
      return lv;
   endfunction

   function automatic spin_item_type random_item();
      spin_item_type it;
      int pick;
      // mostly updates; loads keep stirring the lattice into odd shapes
      it.kind    = ($urandom_range(0, 6) == 0) ? KIND_LOAD : KIND_UPDATE;
      it.row     = COORD_W'($urandom_range(0, LATTICE_SIDE - 1));
      it.col     = COORD_W'($urandom_range(0, LATTICE_SIDE - 1));
      it.spin_up = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
         0: it.rnd = '0;
         1: it.rnd = '1;
         2: begin   // land on or just below a live level
            pick = int'(level_cfg[$urandom_range(0, NUM_LEVELS - 1)])
                   - int'($urandom_range(0, 1));
            if (pick < 0)     pick = 0;
            if (pick > 65535) pick = 65535;
            it.rnd = RND_W'(pick);
         end
         default: it.rnd = RND_W'($urandom);
      endcase
      return it;
   endfunction

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------
   // Offer one item and hold it until accepted. Bursts of random length with
   // random gaps; valid stays high across back-to-back items.
   task automatic send_item(input spin_item_type it, input bit typed,
                            input spin_result_type want);
      int gap;
      spin_result_type got;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid           <= 1'b1;
      req_kind            <= it.kind;
      req_row             <= it.row;
      req_col             <= it.col;
      req_spin_up         <= it.spin_up;
      req_random_fraction <= it.rnd;
      do @(posedge clock); while (req_stall);
      got = apply_item(it);
      expected_results.push_back(typed ? want : got);
   endtask

   // Stop offering and wait for every outstanding result.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [LEVEL_W-1:0] val);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= val;
      @(posedge clock);
      level_cfg[idx] = val;
   endtask

   // Only called with the block idle.
   task automatic program_levels(input accept_levels_type lv);
      write_reg(ACCEPT_DE2, lv[ACCEPT_DE2]);
      write_reg(ACCEPT_DE4, lv[ACCEPT_DE4]);
      write_reg(ACCEPT_DE6, lv[ACCEPT_DE6]);
      write_reg(ACCEPT_DE8, lv[ACCEPT_DE8]);
      csr_write_en <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Receiver: stall pattern changes per segment; honors the long hold
   // ------------------------------------------------------------------
   initial begin : result_stall
      int mode, seg, hold_left;
      hold_left = 0;
      forever begin
         mode = $urandom_range(0, 3);
         seg  = $urandom_range(5, 60);
         repeat (seg) begin
            @(posedge clock);
            if (hold_left == 0 && hold_results) begin
               hold_left    = HOLD_CYCLES;
               hold_results = 1'b0;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_stall <= 1'b1;
            end else begin
               case (mode)
                  0:       rsp_stall <= 1'b0;                        // open
                  1:       rsp_stall <= ($urandom_range(0, 3) == 0); // light
                  2:       rsp_stall <= ($urandom_range(0, 3) != 0); // heavy
                  default: rsp_stall <= ~rsp_stall;                  // toggling
               endcase
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result checking, in order against the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      spin_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with nothing expected: flipped %0d mag %0d energy %0d",
                     $time, rsp_flipped, rsp_magnetization, rsp_energy);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_flipped !== want.flipped) begin
               $display("%0t: flipped expected %0d, actual %0d",
                        $time, want.flipped, rsp_flipped);
               error_count++;
            end
            if (rsp_magnetization !== want.magnetization) begin
               $display("%0t: magnetization expected %0d, actual %0d",
                        $time, want.magnetization, rsp_magnetization);
               error_count++;
            end
            if (rsp_energy !== want.energy) begin
               $display("%0t: energy expected %0d, actual %0d",
                        $time, want.energy, rsp_energy);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      spin_result_type no_result;
      int sent, phase, phase_len;
      no_result = '{default: '0};

      // Directed part. Starts from the reset lattice (all up, M 64, E -112)
      // with every level at "always".
      add_checked(KIND_UPDATE, 0, 0, 1'b0, 0,      1'b1, 62, -108); // corner, dE 4
      add_checked(KIND_LOAD,   0, 0, 1'b0, 16'hFFFF, 1'b0, 62, -108); // load, same value
      add_checked(KIND_LOAD,   0, 0, 1'b1, 0,      1'b1, 64, -112); // load that flips
      add_checked(KIND_UPDATE, 7, 7, 1'b1, 16'hFFFF, 1'b1, 62, -108); // "always" beats max
      add_item   (KIND_UPDATE, 7, 7, 1'b0, 0);                        // dE < 0, back up
      add_checked(KIND_UPDATE, 3, 4, 1'b1, 16'hFFFF, 1'b1, 62, -104); // interior, dE 8
      add_item   (KIND_UPDATE, 3, 4, 1'b0, 16'h1234);
      add_item   (KIND_UPDATE, 0, 5, 1'b0, 16'hFFFF);                 // edge, dE 6
      add_item   (KIND_LOAD,   0, 5, 1'b1, 16'h5A5A);
      // level 0: a positive dE never flips
      add_levels(0, 0, 0, 0);
      add_checked(KIND_UPDATE, 4, 4, 1'b1, 0, 1'b0, 64, -112);
      add_checked(KIND_UPDATE, 0, 0, 1'b0, 0, 1'b0, 64, -112);
      add_checked(KIND_UPDATE, 0, 3, 1'b1, 0, 1'b0, 64, -112);
      add_item   (KIND_LOAD,   2, 2, 1'b0, 16'hABCD);
      add_item   (KIND_UPDATE, 2, 2, 1'b0, 16'hFFFF);                 // dE < 0 still flips
      add_item   (KIND_LOAD,   1, 1, 1'b0, 0);
      add_item   (KIND_UPDATE, 0, 1, 1'b1, 0);                        // dE 2, refused
      add_item   (KIND_LOAD,   1, 3, 1'b0, 0);
      add_item   (KIND_UPDATE, 1, 2, 1'b0, 16'hFFFF);                 // dE 0 always flips
      // levels one step off the boundaries
      add_levels(65535, 1, 32768, 65536);
      add_item   (KIND_UPDATE, 0, 1, 1'b0, 16'hFFFF);                 // level == rnd: no
      add_item   (KIND_UPDATE, 0, 1, 1'b1, 16'hFFFE);                 // level > rnd: yes
      add_item   (KIND_UPDATE, 7, 0, 1'b0, 0);                        // level 1 vs rnd 0
      add_item   (KIND_UPDATE, 7, 0, 1'b1, 16'h8000);
      add_item   (KIND_UPDATE, 7, 3, 1'b0, 16'h7FFF);                 // 32768 vs 32767
      add_item   (KIND_UPDATE, 7, 6, 1'b1, 16'h8000);                 // 32768 vs 32768

      reset_lattice();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].op == ROW_LEVELS) begin
            wait_drained();
            program_levels(directed_rows[i].levels);
         end else begin
            send_item(directed_rows[i].item, directed_rows[i].typed,
                      directed_rows[i].want);
         end
      end

      // Random part: phases with fresh levels, written while idle. Phase 2
      // starts with a long receiver hold so the block backs up into req_stall;
      // phase 4 drains completely halfway through.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_drained();
         program_levels(random_levels());
         phase_len = $urandom_range(60, 140);
         if (phase == 2) hold_results = 1'b1;
         for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
            if (phase == 4 && k == phase_len / 2) wait_drained();
            send_item(random_item(), 1'b0, no_result);
            sent++;
         end
         phase++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/ismu_pkg.sv
src/ismu_front.sv
src/ismu_queue.sv
src/ismu_back.sv
src/ising_metropolis_spin_update_unit.sv
dv/tb.sv
